// ===== sv/mbd_pkg.sv =====
// Shared types and constants for the RGBA8 2x2 mip downsampler.
// No dependencies; the design files refer to this package by scoped names, the bench imports it.
package mbd_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int LINE_DEPTH  = MAX_WIDTH / 2;
    localparam int X_W         = $clog2(LINE_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = 13;
    localparam int HEIGHT_W    = 16;
    localparam int ROW_W       = 16;
    localparam int Y_W         = ROW_W - 1;
    localparam int CHANNELS    = 4;
    localparam int CHAN_W      = 8;
    localparam int PAIR_W      = CHAN_W + 1;
    localparam int TOTAL_W     = CHAN_W + 2;
    localparam int SHIFT_W     = 2;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes, taken from paddr[2]
    localparam logic REG_SRC_WIDTH  = 1'b0;
    localparam logic REG_SRC_HEIGHT = 1'b1;

    typedef logic [CHANNELS-1:0][CHAN_W-1:0] pixel_t;
    typedef logic [CHANNELS-1:0][PAIR_W-1:0] pair_sum_t;

    // what the back end does with a horizontal pair sum
    typedef enum logic [1:0] {
        OP_STORE = 2'd0,   // even row: write the line buffer
        OP_MERGE = 2'd1,   // odd row: add the line buffer entry and emit
        OP_PASS  = 2'd2    // single-row level: emit the pair alone
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [X_W-1:0]   x;
        pair_sum_t        pair;
        logic             hshift;
        logic             last;
    } entry_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]  w_eff;
        logic [HEIGHT_W-1:0] h_eff;
        logic                restart;
    } geom_t;

endpackage

// ===== sv/rgba8_mip_box_downsample.sv =====
// RGBA8 2x2 box-filter mip downsampler, top level.
// Depends on mbd_pkg, mbd_cfg, mbd_front, mbd_queue and mbd_back.
//
// Source pixels of one mip level enter in raster order at one pixel per
// clock; each 2x2 block inside the image leaves as one averaged pixel of the
// next level (sum truncated by the sample count), with level_done marking the
// last one. Odd trailing rows and columns are dropped, a width or height of 1
// is kept. A completed result passes through the queue, the combine stage and
// the output register before out_valid rises, and the input keeps taking one
// pixel per clock as long as the output is drained; the input stalls only
// when the two-entry queue in front of the line buffer fills. The line buffer
// is a single 2048 x 36-bit memory with one access per cycle; it needs no
// clearing after reset. Write src_width and src_height only while the block
// is idle; any write restarts the level.
module rgba8_mip_box_downsample (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbd_pkg::PADDR_W-1:0] paddr,
    input  logic [mbd_pkg::PDATA_W-1:0] pwdata,
    output logic [mbd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  red_in,
    input  logic [7:0]                  green_in,
    input  logic [7:0]                  blue_in,
    input  logic [7:0]                  alpha_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  red_out,
    output logic [7:0]                  green_out,
    output logic [7:0]                  blue_out,
    output logic [7:0]                  alpha_out,
    output logic                        level_done
);

    mbd_pkg::geom_t   geom;
    mbd_pkg::pixel_t  px;
    mbd_pkg::pixel_t  pix_out;
    mbd_pkg::entry_t  wr_entry;
    mbd_pkg::entry_t  head;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             head_valid;

    assign px[0] = red_in;
    assign px[1] = green_in;
    assign px[2] = blue_in;
    assign px[3] = alpha_in;

    assign red_out   = pix_out[0];
    assign green_out = pix_out[1];
    assign blue_out  = pix_out[2];
    assign alpha_out = pix_out[3];

    mbd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom)
    );

    mbd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .geom     (geom),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .px       (px),
        .q_full   (q_full),
        .push     (push),
        .entry    (wr_entry)
    );

    mbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_entry   (wr_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pix_out    (pix_out),
        .level_done (level_done)
    );

endmodule

// ===== sv/mbd_cfg.sv =====
// APB register file for the mip downsampler: source width and height.
// Depends on mbd_pkg; gives the clamped level geometry and a restart pulse.
module mbd_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbd_pkg::PADDR_W-1:0] paddr,
    input  logic [mbd_pkg::PDATA_W-1:0] pwdata,
    output logic [mbd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output mbd_pkg::geom_t              geom
);

    logic [mbd_pkg::WIDTH_W-1:0]  src_width_reg;
    logic [mbd_pkg::HEIGHT_W-1:0] src_height_reg;
    logic                         wr_en;
    logic                         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= mbd_pkg::WIDTH_W'(1);
            src_height_reg <= mbd_pkg::HEIGHT_W'(1);
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                mbd_pkg::REG_SRC_WIDTH:  src_width_reg  <= pwdata[mbd_pkg::WIDTH_W-1:0];
                mbd_pkg::REG_SRC_HEIGHT: src_height_reg <= pwdata[mbd_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            mbd_pkg::REG_SRC_WIDTH:  prdata = mbd_pkg::PDATA_W'(src_width_reg);
            mbd_pkg::REG_SRC_HEIGHT: prdata = mbd_pkg::PDATA_W'(src_height_reg);
            default:                 prdata = '0;
        endcase
    end

    // zero means one; clamp width to the line buffer size
    always_comb
    begin
        if (src_width_reg == '0)
            geom.w_eff = mbd_pkg::WIDTH_W'(1);
        else if (src_width_reg > mbd_pkg::WIDTH_W'(mbd_pkg::MAX_WIDTH))
            geom.w_eff = mbd_pkg::WIDTH_W'(mbd_pkg::MAX_WIDTH);
        else
            geom.w_eff = src_width_reg;
        geom.h_eff   = (src_height_reg == '0) ? mbd_pkg::HEIGHT_W'(1) : src_height_reg;
        geom.restart = wr_en;
    end

endmodule

// ===== sv/mbd_front.sv =====
// Front end of the mip downsampler: raster counters and horizontal pairing.
// Depends on mbd_pkg; pushes one queue entry per completed pair that survives cropping.
module mbd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  mbd_pkg::geom_t      geom,
    input  logic                in_valid,
    output logic                in_ready,
    input  mbd_pkg::pixel_t     px,
    input  logic                q_full,
    output logic                push,
    output mbd_pkg::entry_t     entry
);

    logic [mbd_pkg::COL_W-1:0]   col_reg, col_next;
    logic [mbd_pkg::ROW_W-1:0]   row_reg, row_next;
    mbd_pkg::pixel_t             pending_reg;
    logic                        accept;
    logic                        w_is1, h_is1;
    logic                        col_in, row_in;
    logic                        col_last, row_last;
    logic                        have_pair;
    logic [mbd_pkg::WIDTH_W-1:0] w_even;
    logic [mbd_pkg::ROW_W-1:0]   h_even;
    logic [mbd_pkg::COL_W-1:0]   dst_w;
    logic [mbd_pkg::Y_W-1:0]     dst_h;
    logic [mbd_pkg::X_W-1:0]     x;
    logic [mbd_pkg::Y_W-1:0]     y;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        w_is1    = (geom.w_eff == mbd_pkg::WIDTH_W'(1));
        h_is1    = (geom.h_eff == mbd_pkg::HEIGHT_W'(1));
        w_even   = {geom.w_eff[mbd_pkg::WIDTH_W-1:1], 1'b0};
        h_even   = {geom.h_eff[mbd_pkg::HEIGHT_W-1:1], 1'b0};
        col_in   = mbd_pkg::WIDTH_W'(col_reg) < w_even;
        row_in   = row_reg < h_even;
        col_last = (mbd_pkg::WIDTH_W'(col_reg) + mbd_pkg::WIDTH_W'(1)) == geom.w_eff;
        row_last = (row_reg + mbd_pkg::ROW_W'(1)) == geom.h_eff;

        x     = w_is1 ? '0 : col_reg[mbd_pkg::COL_W-1:1];
        y     = h_is1 ? '0 : row_reg[mbd_pkg::ROW_W-1:1];
        dst_w = w_is1 ? mbd_pkg::COL_W'(1)
                      : mbd_pkg::COL_W'(geom.w_eff[mbd_pkg::WIDTH_W-1:1]);
        dst_h = h_is1 ? mbd_pkg::Y_W'(1) : geom.h_eff[mbd_pkg::HEIGHT_W-1:1];

        have_pair    = 1'b0;
        entry.hshift = 1'b0;
        for (int i = 0; i < mbd_pkg::CHANNELS; i++)
            entry.pair[i] = mbd_pkg::PAIR_W'(px[i]);
        if (w_is1)
            have_pair = 1'b1;
        else if (col_in && col_reg[0])
        begin
            have_pair    = 1'b1;
            entry.hshift = 1'b1;
            for (int i = 0; i < mbd_pkg::CHANNELS; i++)
                entry.pair[i] = mbd_pkg::PAIR_W'(pending_reg[i]) + mbd_pkg::PAIR_W'(px[i]);
        end

        if (h_is1)
            entry.op = mbd_pkg::OP_PASS;
        else if (row_reg[0])
            entry.op = mbd_pkg::OP_MERGE;
        else
            entry.op = mbd_pkg::OP_STORE;

        entry.x    = x;
        entry.last = ((mbd_pkg::COL_W'(x) + mbd_pkg::COL_W'(1)) == dst_w)
                  && ((mbd_pkg::ROW_W'(y) + mbd_pkg::ROW_W'(1)) == mbd_pkg::ROW_W'(dst_h));

        push = accept && have_pair && (h_is1 || row_in);

        // wrap at the end of each row and of the level
        col_next = col_reg + mbd_pkg::COL_W'(1);
        row_next = row_reg;
        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_reg + mbd_pkg::ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            pending_reg <= '0;
        end
        else if (geom.restart)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            pending_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            // hold the even-column pixel for its partner
            if (!w_is1 && col_in && !col_reg[0])
                pending_reg <= px;
        end
    end

endmodule

// ===== sv/mbd_queue.sv =====
// Short FIFO of pair-sum entries between the front and back ends.
// Depends on mbd_pkg for the entry type and depth.
module mbd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mbd_pkg::entry_t  wr_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output mbd_pkg::entry_t  head
);

    mbd_pkg::entry_t              slot_reg [mbd_pkg::QUEUE_DEPTH];
    logic [mbd_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [mbd_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == mbd_pkg::QCNT_W'(mbd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + mbd_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - mbd_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == mbd_pkg::QPTR_W'(mbd_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + mbd_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == mbd_pkg::QPTR_W'(mbd_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + mbd_pkg::QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

// ===== sv/mbd_back.sv =====
// Back end of the mip downsampler: line buffer of pair sums, vertical add,
// divide by sample count and the output register. Depends on mbd_pkg.
module mbd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  mbd_pkg::entry_t            head,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output mbd_pkg::pixel_t            pix_out,
    output logic                       level_done
);

    mbd_pkg::pair_sum_t                line_mem [mbd_pkg::LINE_DEPTH];
    mbd_pkg::pair_sum_t                rd_reg;
    mbd_pkg::entry_t                   s1_reg;
    logic                              s1_valid_reg, s1_valid_next;
    logic                              s1_adv;
    logic                              s1_free;
    logic                              out_valid_reg, out_valid_next;
    mbd_pkg::pixel_t                   pix_reg, pix_next;
    logic                              done_reg;
    logic [mbd_pkg::SHIFT_W-1:0]       shift;
    logic [mbd_pkg::TOTAL_W-1:0]       total;
    logic [mbd_pkg::TOTAL_W-1:0]       scaled;

    assign s1_adv  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_free = !s1_valid_reg || s1_adv;
    // stores need no slot in the combine stage
    assign pop     = head_valid && ((head.op == mbd_pkg::OP_STORE) || s1_free);

    // line buffer: at most one write or one read per transfer from the queue
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (head.op == mbd_pkg::OP_STORE)
                line_mem[head.x] <= head.pair;
            // hold the read data for the merge sitting in the combine stage
            if (head.op == mbd_pkg::OP_MERGE)
                rd_reg <= line_mem[head.x];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pop && (head.op != mbd_pkg::OP_STORE))
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        shift = mbd_pkg::SHIFT_W'(s1_reg.hshift)
              + mbd_pkg::SHIFT_W'(s1_reg.op == mbd_pkg::OP_MERGE);
        total  = '0;
        scaled = '0;
        for (int i = 0; i < mbd_pkg::CHANNELS; i++)
        begin
            if (s1_reg.op == mbd_pkg::OP_MERGE)
                total = mbd_pkg::TOTAL_W'(rd_reg[i]) + mbd_pkg::TOTAL_W'(s1_reg.pair[i]);
            else
                total = mbd_pkg::TOTAL_W'(s1_reg.pair[i]);
            scaled      = total >> shift;
            pix_next[i] = scaled[mbd_pkg::CHAN_W-1:0];
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (head.op != mbd_pkg::OP_STORE))
            s1_reg <= head;
        if (s1_adv)
        begin
            pix_reg  <= pix_next;
            done_reg <= s1_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pix_out    = pix_reg;
    assign level_done = done_reg;

endmodule

// ===== verif/rgba8_mip_box_downsample_tb.sv =====
// Self-checking bench for the RGBA8 2x2 box-filter mip downsampler.
// Needs mbd_pkg and rgba8_mip_box_downsample. A built-in predictor averages
// each 2x2 block and checks every output transfer against it.
`timescale 1ns / 100ps

module rgba8_mip_box_downsample_tb;
    import mbd_pkg::*;

    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_CYCLES  = 300;
    localparam int TIMEOUT_NS    = 10_000_000;
    localparam int RANDOM_PIXELS = 1200;

    typedef struct packed {
        pixel_t px;
        logic   done;
    } dst_pixel_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         red_in = '0;
    logic [7:0]         green_in = '0;
    logic [7:0]         blue_in = '0;
    logic [7:0]         alpha_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic [7:0]         alpha_out;
    logic               level_done;

    rgba8_mip_box_downsample dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .alpha_in   (alpha_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .alpha_out  (alpha_out),
        .level_done (level_done)
    );

    // predictor state
    logic [WIDTH_W-1:0]  geom_width = 1;
    logic [HEIGHT_W-1:0] geom_height = 1;
    int                  col_count = 0;
    int                  row_count = 0;
    pixel_t              even_px = '0;
    pair_sum_t           row_sums [LINE_DEPTH];
    dst_pixel_t          avg_expected [$];

    // stimulus and flow control
    pixel_t src_pixels [$];
    int     pixels_left = 0;
    int     src_wait = 0;
    int     dst_wait = 0;
    int     src_max_gap = 6;
    int     dst_max_gap = 6;
    int     hold_left = 0;
    logic   src_xfer = 1'b0;
    logic   dst_xfer = 1'b0;

    int errors = 0;
    int pixels_in = 0;
    int avgs_checked = 0;
    int geometries = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("rgba8_mip_box_downsample_tb: done, errors");
        $finish;
    end

    // Advance the predictor by one accepted source pixel.
    function automatic void downsample_pixel(pixel_t px);
        int                w;
        int                h;
        int                x;
        int                y;
        int                shift;
        int                dst_w;
        int                dst_h;
        logic              have_pair;
        logic              emit;
        logic [PAIR_W-1:0] pair [CHANNELS];
        logic [TOTAL_W-1:0] total [CHANNELS];
        dst_pixel_t        res;

        w = (geom_width == 0) ? 1 : ((geom_width > MAX_WIDTH) ? MAX_WIDTH : int'(geom_width));
        h = (geom_height == 0) ? 1 : int'(geom_height);
        x = 0;
        shift = 0;
        have_pair = 1'b0;
        emit = 1'b0;

        if (w == 1)
        begin
            for (int i = 0; i < CHANNELS; i++)
                pair[i] = px[i];
            have_pair = 1'b1;
        end
        else if (col_count < 2 * (w / 2))
        begin
            x = col_count / 2;
            if (col_count % 2 == 0)
                even_px = px;
            else
            begin
                for (int i = 0; i < CHANNELS; i++)
                    pair[i] = even_px[i] + px[i];
                have_pair = 1'b1;
                shift = 1;
            end
        end

        if (have_pair && x < LINE_DEPTH)
        begin
            if (h == 1)
            begin
                for (int i = 0; i < CHANNELS; i++)
                    total[i] = pair[i];
                emit = 1'b1;
            end
            else if (row_count < 2 * (h / 2))
            begin
                if (row_count % 2 == 0)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                        row_sums[x][i] = pair[i];
                end
                else
                begin
                    for (int i = 0; i < CHANNELS; i++)
                        total[i] = row_sums[x][i] + pair[i];
                    emit = 1'b1;
                    shift++;
                end
            end
        end

        if (emit)
        begin
            y = (h == 1) ? 0 : row_count / 2;
            dst_w = (w == 1) ? 1 : w / 2;
            dst_h = (h == 1) ? 1 : h / 2;
            for (int i = 0; i < CHANNELS; i++)
                res.px[i] = 8'(total[i] >> shift);
            res.done = (x + 1 == dst_w) && (y + 1 == dst_h);
            avg_expected.push_back(res);
        end

        // wrap at the end of each row and of the level
        col_count++;
        if (col_count >= w)
        begin
            col_count = 0;
            row_count++;
            if (row_count >= h)
                row_count = 0;
        end
    endfunction

    function automatic pixel_t rgba(input logic [7:0] r, g, b, a);
        return {a, b, g, r};
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        for (int i = 0; i < CHANNELS; i++)
        begin
            case ($urandom_range(0, 7))
                0: p[i] = 8'h00;
                1: p[i] = 8'hFF;
                default: p[i] = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    task automatic push_pixel(pixel_t p);
        src_pixels.push_back(p);
        pixels_left++;
    endtask

    task automatic push_random(int n);
        for (int i = 0; i < n; i++)
            push_pixel(rand_pixel());
    endtask

    // Block until every pixel is taken and every average has come out, then let
    // the pipeline settle so trailing pixels that make no output are flushed.
    task automatic wait_idle();
        @(negedge clk);
        while (pixels_left != 0 || avg_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_SRC_WIDTH)
            geom_width = value[WIDTH_W-1:0];
        else
            geom_height = value[HEIGHT_W-1:0];
        // any register write restarts the level
        col_count = 0;
        row_count = 0;
        even_px = '0;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_geometry(int w, int h);
        apb_write(REG_SRC_WIDTH, PDATA_W'(w));
        apb_write(REG_SRC_HEIGHT, PDATA_W'(h));
        geometries++;
    endtask

    // source side: one transfer per pixel, random gap before each
    always @(negedge clk)
    begin : src_drive
        logic   nxt_valid;
        pixel_t p;

        nxt_valid = in_valid && !src_xfer;
        if (rst_n && !nxt_valid)
        begin
            if (src_wait != 0)
                src_wait--;
            else if (src_pixels.size() != 0)
            begin
                p = src_pixels.pop_front();
                red_in <= p[0];
                green_in <= p[1];
                blue_in <= p[2];
                alpha_in <= p[3];
                nxt_valid = 1'b1;
                src_wait = $urandom_range(0, src_max_gap);
            end
        end
        in_valid <= nxt_valid;
    end

    // sink side: random stall after each transfer, plus the long hold-off
    always @(negedge clk)
    begin
        if (dst_xfer)
            dst_wait = $urandom_range(0, dst_max_gap);
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (dst_wait != 0)
        begin
            dst_wait--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : watch
        pixel_t     got;
        dst_pixel_t want;
        string      names [CHANNELS];

        names = '{"red_out", "green_out", "blue_out", "alpha_out"};
        src_xfer <= rst_n && in_valid && in_ready;
        dst_xfer <= rst_n && out_valid && out_ready;
        if (rst_n && in_valid && in_ready)
        begin
            downsample_pixel({alpha_in, blue_in, green_in, red_in});
            pixels_left--;
            pixels_in++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (avg_expected.size() == 0)
            begin
                $error("output transfer with nothing expected");
                errors++;
            end
            else
            begin
                want = avg_expected.pop_front();
                got = {alpha_out, blue_out, green_out, red_out};
                avgs_checked++;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (got[i] !== want.px[i])
                    begin
                        $error("%s: expected %0d, got %0d", names[i], want.px[i], got[i]);
                        errors++;
                    end
                end
                if (level_done !== want.done)
                begin
                    $error("level_done: expected %0d, got %0d", want.done, level_done);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int w;
        int h;
        int we;
        int he;
        int n;
        int random_sent;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // after reset the level is 1x1: every pixel passes through and ends it
        src_max_gap = 0;
        dst_max_gap = 0;
        push_pixel(rgba(8'h00, 8'h00, 8'h00, 8'h00));
        push_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        push_pixel(rgba(8'hAA, 8'h55, 8'h0F, 8'hF0));
        push_pixel(rgba(8'h55, 8'hAA, 8'hF0, 8'h0F));
        wait_idle();

        // odd trailing row and column dropped, sums truncated by four
        set_geometry(3, 3);
        push_pixel(rgba(8'hFF, 8'h00, 8'h01, 8'h80));
        push_pixel(rgba(8'hFE, 8'h00, 8'h02, 8'h81));
        push_pixel(rgba(8'h12, 8'h34, 8'h56, 8'h78));
        push_pixel(rgba(8'hFD, 8'h00, 8'h03, 8'h82));
        push_pixel(rgba(8'hFB, 8'h01, 8'h00, 8'h83));
        push_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        push_pixel(rgba(8'h00, 8'h00, 8'h00, 8'h00));
        push_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        push_pixel(rgba(8'h9A, 8'hBC, 8'hDE, 8'hF0));
        wait_idle();

        // single column: vertical pairs only
        set_geometry(1, 4);
        push_pixel(rgba(8'hFF, 8'h01, 8'h00, 8'h7F));
        push_pixel(rgba(8'hFE, 8'h00, 8'h00, 8'h80));
        push_pixel(rgba(8'h00, 8'hFF, 8'hFF, 8'h01));
        push_pixel(rgba(8'h01, 8'hFF, 8'hFE, 8'h00));
        wait_idle();

        // single row: horizontal pairs only, last column dropped
        set_geometry(5, 1);
        push_pixel(rgba(8'hFF, 8'h03, 8'h80, 8'h00));
        push_pixel(rgba(8'hFE, 8'h00, 8'h7F, 8'h01));
        push_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        push_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFE));
        push_pixel(rgba(8'h11, 8'h22, 8'h33, 8'h44));
        wait_idle();

        // zero size reads as one
        set_geometry(0, 0);
        push_pixel(rgba(8'hC3, 8'h3C, 8'h00, 8'hFF));
        push_pixel(rgba(8'h00, 8'hFF, 8'hC3, 8'h3C));
        wait_idle();

        // hold the output long enough for the input to back up
        set_geometry(8, 8);
        src_max_gap = 0;
        dst_max_gap = 0;
        push_random(128);
        @(posedge clk);
        hold_left = STALL_CYCLES;
        wait_idle();

        // width beyond the line buffer saturates; run part of the first row
        set_geometry(8191, 2);
        src_max_gap = 2;
        dst_max_gap = 2;
        push_random(256);
        wait_idle();

        // tallest level, cut short by the next restart
        set_geometry(2, 65535);
        src_max_gap = 6;
        dst_max_gap = 6;
        push_random(40);
        wait_idle();

        random_sent = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 9))
                0: w = 0;
                1: w = 1;
                8, 9: w = $urandom_range(13, 64);
                default: w = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 9))
                0: h = 0;
                1: h = 1;
                9: h = $urandom_range(11, 65535);
                default: h = $urandom_range(2, 10);
            endcase
            we = (w == 0) ? 1 : w;
            he = (h == 0) ? 1 : h;
            n = (he > 400) ? 400 : we * he * $urandom_range(1, 2);
            // sometimes restart mid-level
            if (n > 400 || $urandom_range(0, 4) == 0)
                n = $urandom_range(1, (n > 400) ? 400 : n);
            src_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
            dst_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
            set_geometry(w, h);
            push_random(n);
            random_sent += n;
            wait_idle();
        end

        $display("%0d source pixels over %0d geometries, %0d averaged pixels checked",
                 pixels_in, geometries, avgs_checked);
        $display("covered 1x1 pass-through, odd edges, oversized width, backpressure stall");
        if (errors == 0 && avg_expected.size() == 0)
            $display("rgba8_mip_box_downsample_tb: done, clean");
        else
            $display("rgba8_mip_box_downsample_tb: done, errors");
        $finish;
    end

endmodule
